### design/scfr_pkg.sv
// ----------------------------------------------------------------------------
// scfr_pkg
// Types and constants shared by the serial command frame receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

	localparam int BUFFER_DEPTH = 64;
	// data byte counter only has to reach BUFFER_DEPTH
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_HEADER_VALUE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SID_MASK = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_IM_TIMEOUT = 2'd3;

	localparam logic [7:0] HEADER_RESET = 8'd81;
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] EV_DATA = 2'd0;
	localparam logic [1:0] EV_ACCEPT = 2'd1;
	localparam logic [1:0] EV_BADCHECK = 2'd2;
	localparam logic [1:0] EV_IDLE = 2'd3;

	typedef enum logic [3:0] {
		PH_WAIT = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_SID = 4'b0100,
		PH_RECV = 4'b1000
	} phase_t;

	typedef struct packed {
		logic opcode;
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [7:0] service_id;
		logic [5:0] data_index;
		logic [7:0] data_value;
		logic [7:0] frame_length;
	} rpt_item_t;

	typedef struct packed {
		logic [7:0] header_value;
		logic [63:0] accepted_sid_mask;
		logic [31:0] idle_timeout;
		logic [31:0] inter_message_timeout;
	} cfg_t;

endpackage

### design/scfr_cfg.sv
// ----------------------------------------------------------------------------
// scfr_cfg
// APB register file holding the receiver configuration.
// ----------------------------------------------------------------------------
module scfr_cfg import scfr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	// registers sit on 8-byte boundaries
	assign reg_idx = paddr[PADDR_W-1:3];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_value <= HEADER_RESET;
			cfg_q.accepted_sid_mask <= '0;
			cfg_q.idle_timeout <= TIMEOUT_RESET;
			cfg_q.inter_message_timeout <= TIMEOUT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HEADER_VALUE: cfg_q.header_value <= pwdata[7:0];
				REG_SID_MASK: cfg_q.accepted_sid_mask <= pwdata;
				REG_IDLE_TIMEOUT: cfg_q.idle_timeout <= pwdata[31:0];
				REG_IM_TIMEOUT: cfg_q.inter_message_timeout <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HEADER_VALUE: prdata = {56'd0, cfg_q.header_value};
			REG_SID_MASK: prdata = cfg_q.accepted_sid_mask;
			REG_IDLE_TIMEOUT: prdata = {32'd0, cfg_q.idle_timeout};
			REG_IM_TIMEOUT: prdata = {32'd0, cfg_q.inter_message_timeout};
			default: prdata = '0;
		endcase
	end

endmodule

### design/scfr_engine.sv
// ----------------------------------------------------------------------------
// scfr_engine
// Frame state machine with its result register.
// ----------------------------------------------------------------------------
module scfr_engine import scfr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic item_valid_s1,
	input rx_item_t item_s1,
	output logic advance,
	output logic rpt_valid,
	input logic rpt_stall,
	output rpt_item_t rpt
);

	phase_t phase_q, phase_d;
	logic [31:0] tick_count_q, tick_count_d;
	logic [7:0] running_check_q, running_check_d;
	logic [CNT_W-1:0] bytes_taken_q, bytes_taken_d;
	logic [7:0] declared_length_q, declared_length_d;
	logic [7:0] current_sid_q, current_sid_d;

	logic rpt_valid_q;
	rpt_item_t rpt_q;

	logic has_rpt;
	logic [1:0] kind;
	logic [5:0] idx;
	logic [7:0] val;
	logic [31:0] tick_inc;
	logic [7:0] b;
	logic take;

	assign advance = !rpt_valid_q || !rpt_stall;
	assign take = item_valid_s1 && advance;
	assign b = item_s1.rx_byte;
	assign tick_inc = (tick_count_q == '1) ? tick_count_q : tick_count_q + 32'd1;

	always_comb begin
		phase_d = phase_q;
		tick_count_d = tick_count_q;
		running_check_d = running_check_q;
		bytes_taken_d = bytes_taken_q;
		declared_length_d = declared_length_q;
		current_sid_d = current_sid_q;
		has_rpt = 1'b0;
		kind = EV_DATA;
		idx = '0;
		val = '0;
		if (item_s1.opcode == OP_TICK) begin
			tick_count_d = tick_inc;
			if (phase_q == PH_WAIT) begin
				if (tick_inc >= cfg.idle_timeout) begin
					tick_count_d = '0;
					has_rpt = 1'b1;
					kind = EV_IDLE;
				end
			end else if (phase_q == PH_RECV) begin
				if (tick_inc >= cfg.inter_message_timeout)
					phase_d = PH_WAIT;
			end
		end else begin
			case (phase_q)
				PH_WAIT: begin
					if (b == cfg.header_value) begin
						phase_d = PH_HEADER;
						running_check_d = b;
						bytes_taken_d = '0;
					end
				end
				PH_HEADER: begin
					current_sid_d = b;
					if (b[7:6] == 2'b00 && cfg.accepted_sid_mask[b[5:0]]) begin
						phase_d = PH_SID;
						running_check_d = running_check_q | b;
					end
				end
				PH_SID: begin
					declared_length_d = b;
					running_check_d = running_check_q | b;
					phase_d = (b > 8'(BUFFER_DEPTH)) ? PH_WAIT : PH_RECV;
				end
				PH_RECV: begin
					has_rpt = 1'b1;
					if (8'(bytes_taken_q) < declared_length_q) begin
						running_check_d = running_check_q | b;
						bytes_taken_d = bytes_taken_q + 1'b1;
						kind = EV_DATA;
						idx = 6'(bytes_taken_q);
						val = b;
					end else begin
						phase_d = PH_WAIT;
						if (running_check_q != b) begin
							kind = EV_BADCHECK;
						end else begin
							tick_count_d = '0;
							kind = EV_ACCEPT;
						end
					end
				end
				default: phase_d = PH_WAIT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			tick_count_q <= '0;
			running_check_q <= '0;
			bytes_taken_q <= '0;
			declared_length_q <= '0;
			current_sid_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			tick_count_q <= tick_count_d;
			running_check_q <= running_check_d;
			bytes_taken_q <= bytes_taken_d;
			declared_length_q <= declared_length_d;
			current_sid_q <= current_sid_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (advance) begin
			rpt_valid_q <= take && has_rpt;
		end
	end

	// reports carry the sid and length as they stand after the item
	always_ff @(posedge clk) begin
		if (take && has_rpt) begin
			rpt_q.event_kind <= kind;
			rpt_q.service_id <= current_sid_d;
			rpt_q.data_index <= idx;
			rpt_q.data_value <= val;
			rpt_q.frame_length <= declared_length_d;
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt = rpt_q;

endmodule

### design/serial_command_frame_receiver.sv
// ----------------------------------------------------------------------------
// serial_command_frame_receiver
// Frame receiver for header, service id, length, data and check bytes.
// ----------------------------------------------------------------------------
// Takes one item per clock while the item channel is not stalled: a received
// byte or a time tick. Each item is held in an input register; the frame
// engine then updates its state and loads a report into the output register,
// where the report is presented until it is taken. Items flow back to back as
// long as the report side is not stalled; a stalled report holds the input
// register and stalls the item channel. Data bytes give one report each; the
// check byte gives an accept or bad-check report; ticks while waiting for a
// header give an idle timeout report once the idle timeout is reached.
// Registers are at byte addresses 0, 8, 16 and 24 on the 64-bit APB port.
module serial_command_frame_receiver import scfr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input rx_item_t item,
	output logic rpt_valid,
	input logic rpt_stall,
	output rpt_item_t rpt,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready
);

	cfg_t cfg;
	logic advance;
	logic item_valid_s1;
	rx_item_t item_s1;
	logic load;

	scfr_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign item_stall = item_valid_s1 && !advance;
	assign load = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_valid_s1 || advance) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

	scfr_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.item_valid_s1(item_valid_s1),
		.item_s1(item_s1),
		.advance(advance),
		.rpt_valid(rpt_valid),
		.rpt_stall(rpt_stall),
		.rpt(rpt)
	);

endmodule
